/* design/jvsv_pkg.sv */
// Shared types, status codes and literal tables for the JSON value validator.
package jvsv_pkg;

  localparam int MAX_DEPTH_DEF   = 32;
  localparam int LENGTH_BITS_DEF = 32;
  localparam int SPAN_W          = 32;
  localparam int STATUS_W        = 2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEEP = 2'd2;

  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_F   = 8'h66;

  typedef struct packed {
    logic       restart;
    logic       end_of_input;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SPAN_W-1:0]   span_length;
  } result_t;

  // Expected byte of "null", "true", "false" at a position
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (kind)
      LIT_NULL: begin
        unique case (pos)
          3'd0:    c = 8'h6E;
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
      LIT_TRUE: begin
        unique case (pos)
          3'd0:    c = 8'h74;
          3'd1:    c = 8'h72;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (pos)
          3'd0:    c = 8'h66;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h73;
          3'd4:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] n;
    unique case (kind)
      LIT_NULL:  n = 3'd4;
      LIT_TRUE:  n = 3'd4;
      LIT_FALSE: n = 3'd5;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

/* design/jvsv_in_stage.sv */
// Input register stage for the JSON validator byte stream.
module jvsv_in_stage
  import jvsv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

/* design/jvsv_scan.sv */
// Scanner state machine: phase, container stack, depth and byte count.
module jvsv_scan
  import jvsv_pkg::*;
#(
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output logic    res_emit,
  output result_t res
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int LB = LENGTH_BITS;

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_VALUE     = 5'd1;
  localparam logic [4:0] PH_ARR_FIRST = 5'd2;
  localparam logic [4:0] PH_OBJ_FIRST = 5'd3;
  localparam logic [4:0] PH_OBJ_KEY   = 5'd4;
  localparam logic [4:0] PH_KEY_STR   = 5'd5;
  localparam logic [4:0] PH_KEY_ESC   = 5'd6;
  localparam logic [4:0] PH_COLON     = 5'd7;
  localparam logic [4:0] PH_AFTER     = 5'd8;
  localparam logic [4:0] PH_STR       = 5'd9;
  localparam logic [4:0] PH_STR_ESC   = 5'd10;
  localparam logic [4:0] PH_LIT       = 5'd11;
  localparam logic [4:0] PH_NUM_SIGN  = 5'd12;
  localparam logic [4:0] PH_NUM_ZERO  = 5'd13;
  localparam logic [4:0] PH_NUM_INT   = 5'd14;
  localparam logic [4:0] PH_FRAC0     = 5'd15;
  localparam logic [4:0] PH_FRAC      = 5'd16;
  localparam logic [4:0] PH_EXP0      = 5'd17;
  localparam logic [4:0] PH_EXPS      = 5'd18;
  localparam logic [4:0] PH_EXP       = 5'd19;

  logic [4:0]           phase_r, phase_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [2:0]           pos_r, pos_nxt;
  logic [DW-1:0]        depth_r, depth_nxt;
  logic [LB-1:0]        cnt_r, cnt_nxt;
  logic [MAX_DEPTH-1:0] stack_r, stack_nxt;

  logic [LB-1:0]        len_v;
  logic [STATUS_W-1:0]  status_v;
  logic [SPAN_W-1:0]    span_v;

  always_comb begin
    logic [4:0]    ph0, ph, nx;
    logic [DW-1:0] d0, d_after;
    logic [LB-1:0] c0, c1;
    logic [7:0]    b;
    logic          is_num, num_end, dg, ee;
    logic          start, open, open_kind, close, done, fail, deep, top;

    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    pos_nxt   = pos_r;
    depth_nxt = depth_r;
    cnt_nxt   = cnt_r;
    stack_nxt = stack_r;
    res_emit  = 1'b0;
    status_v  = ST_OK;
    len_v     = '0;

    b  = item.data_byte;
    ph0 = item.restart ? PH_VALUE : phase_r;
    d0  = item.restart ? '0 : depth_r;
    c0  = item.restart ? '0 : cnt_r;
    c1  = (&c0) ? c0 : c0 + LB'(1);
    dg  = is_digit(b);
    ee  = (b == CH_LC_E) || (b == CH_UC_E);
    top = (d0 != '0) ? stack_r[0] : 1'b0;

    is_num = (ph0 == PH_NUM_ZERO) || (ph0 == PH_NUM_INT) ||
             (ph0 == PH_FRAC) || (ph0 == PH_EXP);
    // Phase a number moves to on this byte; IDLE means the number has ended
    priority case (ph0)
      PH_NUM_ZERO: nx = (b == CH_DOT) ? PH_FRAC0 : (ee ? PH_EXP0 : PH_IDLE);
      PH_NUM_INT:  nx = dg ? PH_NUM_INT :
                        ((b == CH_DOT) ? PH_FRAC0 : (ee ? PH_EXP0 : PH_IDLE));
      PH_FRAC:     nx = dg ? PH_FRAC : (ee ? PH_EXP0 : PH_IDLE);
      default:     nx = dg ? PH_EXP : PH_IDLE;
    endcase
    num_end = is_num && (nx == PH_IDLE);

    start = 1'b0; open = 1'b0; open_kind = 1'b0; close = 1'b0;
    done = 1'b0; fail = 1'b0; deep = 1'b0;
    d_after = d0;
    ph = num_end ? PH_AFTER : ph0;

    if (fire) begin
      phase_nxt = ph0;
      depth_nxt = d0;
      cnt_nxt   = c0;
      if (item.restart) begin
        kind_nxt = LIT_NULL;
        pos_nxt  = 3'd0;
      end
      if (ph0 != PH_IDLE) begin
        if (item.end_of_input) begin
          res_emit  = 1'b1;
          phase_nxt = PH_IDLE;
          if (is_num && (d0 == '0)) begin
            status_v = ST_OK;
            len_v    = c0;
          end else begin
            status_v = ST_BAD;
          end
        end else if (num_end && (d0 == '0)) begin
          // terminating byte of a top-level number is not counted
          res_emit  = 1'b1;
          status_v  = ST_OK;
          len_v     = c0;
          phase_nxt = PH_IDLE;
        end else begin
          cnt_nxt = c1;
          unique case (ph)
            PH_VALUE: start = 1'b1;
            PH_ARR_FIRST: begin
              if (b == CH_RBRACK) close = 1'b1;
              else                start = 1'b1;
            end
            PH_OBJ_FIRST: begin
              if (b == CH_RBRACE)     close = 1'b1;
              else if (b == CH_QUOTE) phase_nxt = PH_KEY_STR;
              else                    fail = 1'b1;
            end
            PH_OBJ_KEY: begin
              if (b == CH_QUOTE) phase_nxt = PH_KEY_STR;
              else               fail = 1'b1;
            end
            PH_KEY_STR: begin
              if (b == CH_BSLASH)     phase_nxt = PH_KEY_ESC;
              else if (b == CH_QUOTE) phase_nxt = PH_COLON;
            end
            PH_KEY_ESC: phase_nxt = PH_KEY_STR;
            PH_COLON: begin
              if (b == CH_COLON) phase_nxt = PH_VALUE;
              else               fail = 1'b1;
            end
            PH_AFTER: begin
              if (b == CH_COMMA) begin
                phase_nxt = top ? PH_OBJ_KEY : PH_VALUE;
              end else if ((b == CH_RBRACK && !top) || (b == CH_RBRACE && top)) begin
                close = 1'b1;
              end else begin
                fail = 1'b1;
              end
            end
            PH_STR: begin
              if (b == CH_BSLASH)     phase_nxt = PH_STR_ESC;
              else if (b == CH_QUOTE) done = 1'b1;
            end
            PH_STR_ESC: phase_nxt = PH_STR;
            PH_LIT: begin
              if ((pos_r >= lit_len(kind_r)) || (b != lit_char(kind_r, pos_r))) begin
                fail = 1'b1;
              end else begin
                pos_nxt = pos_r + 3'd1;
                if ((pos_r + 3'd1) == lit_len(kind_r)) done = 1'b1;
              end
            end
            PH_NUM_SIGN: begin
              if (b == CH_ZERO) phase_nxt = PH_NUM_ZERO;
              else if (dg)      phase_nxt = PH_NUM_INT;
              else              fail = 1'b1;
            end
            PH_FRAC0: begin
              if (dg) phase_nxt = PH_FRAC;
              else    fail = 1'b1;
            end
            PH_EXP0: begin
              if (b == CH_PLUS || b == CH_MINUS) phase_nxt = PH_EXPS;
              else if (dg)                       phase_nxt = PH_EXP;
              else                               fail = 1'b1;
            end
            PH_EXPS: begin
              if (dg) phase_nxt = PH_EXP;
              else    fail = 1'b1;
            end
            PH_NUM_ZERO, PH_NUM_INT, PH_FRAC, PH_EXP: phase_nxt = nx;
            default: phase_nxt = phase_r;
          endcase

          if (start) begin
            if (b == CH_LC_N || b == CH_LC_T || b == CH_LC_F) begin
              kind_nxt  = (b == CH_LC_N) ? LIT_NULL : ((b == CH_LC_T) ? LIT_TRUE : LIT_FALSE);
              pos_nxt   = 3'd1;
              phase_nxt = PH_LIT;
            end else if (b == CH_MINUS) begin
              phase_nxt = PH_NUM_SIGN;
            end else if (b == CH_ZERO) begin
              phase_nxt = PH_NUM_ZERO;
            end else if (dg) begin
              phase_nxt = PH_NUM_INT;
            end else if (b == CH_QUOTE) begin
              phase_nxt = PH_STR;
            end else if (b == CH_LBRACK) begin
              open = 1'b1;
            end else if (b == CH_LBRACE) begin
              open      = 1'b1;
              open_kind = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end

          if (open) begin
            if (d0 >= DW'(MAX_DEPTH)) begin
              fail = 1'b1;
              deep = 1'b1;
            end else begin
              // stack is a shift line with the innermost container at bit 0
              stack_nxt = {stack_r[MAX_DEPTH-2:0], open_kind};
              depth_nxt = d0 + DW'(1);
              phase_nxt = open_kind ? PH_OBJ_FIRST : PH_ARR_FIRST;
            end
          end

          if (close) begin
            if (d0 != '0) begin
              d_after   = d0 - DW'(1);
              stack_nxt = {1'b0, stack_r[MAX_DEPTH-1:1]};
            end
            depth_nxt = d_after;
            done      = 1'b1;
          end

          if (done) begin
            if (d_after == '0) begin
              res_emit  = 1'b1;
              status_v  = ST_OK;
              len_v     = c1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_AFTER;
            end
          end

          if (fail) begin
            res_emit  = 1'b1;
            status_v  = deep ? ST_DEEP : ST_BAD;
            len_v     = '0;
            phase_nxt = PH_IDLE;
          end
        end
      end
    end
  end

  generate
    if (LB > SPAN_W) begin : g_len_sat
      assign span_v = (|len_v[LB-1:SPAN_W]) ? {SPAN_W{1'b1}} : len_v[SPAN_W-1:0];
    end else if (LB == SPAN_W) begin : g_len_eq
      assign span_v = len_v;
    end else begin : g_len_ext
      assign span_v = {{(SPAN_W-LB){1'b0}}, len_v};
    end
  endgenerate

  assign res = {status_v, span_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= LIT_NULL;
      pos_r   <= 3'd0;
      depth_r <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      pos_r   <= pos_nxt;
      depth_r <= depth_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
  end

endmodule

/* design/json_value_skip_validator.sv */
// Results: the input stage registers the ending transaction, res_r its result.
// Throughput: one byte per cycle; the scan stage takes a byte every cycle the
// result register is free or being drained.
// Reset (rst_n, synchronous): clears scan phase, depth, byte count and valids;
// the container stack holds no reset value and is written before it is read.
module json_value_skip_validator
  import jvsv_pkg::*;
#(
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] restart, [1] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [33:2] span_length, [39:34] zero
);

  item_t   in_item, item;
  result_t res, res_r;
  logic    item_valid, advance, res_emit, out_valid_r;

  assign in_item.restart      = in_tuser[0];
  assign in_item.end_of_input = in_tuser[1];
  assign in_item.data_byte    = in_tdata;

  assign advance = !out_valid_r || out_tready;

  jvsv_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  jvsv_scan #(
    .MAX_DEPTH   (MAX_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (item_valid && advance),
    .item     (item),
    .res_emit (res_emit),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && res_emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.span_length, res_r.status};

endmodule

/* tb/json_value_skip_validator_chk.sv */
// Checker for the JSON value validator: tracks the scan per transaction and compares results.
module json_value_skip_validator_chk
  import jvsv_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] restart, [1] end_of_input
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [1:0] status, [33:2] span_length, [39:34] zero
  output int          pending,
  output int          errors
);

  typedef enum logic [4:0] {
    SC_IDLE, SC_VALUE, SC_ARR_FIRST, SC_OBJ_FIRST, SC_OBJ_KEY, SC_KEY_STR, SC_KEY_ESC,
    SC_COLON, SC_AFTER, SC_STR, SC_STR_ESC, SC_LIT, SC_NUM_SIGN, SC_NUM_ZERO, SC_NUM_INT,
    SC_FRAC0, SC_FRAC, SC_EXP0, SC_EXP_SIGN, SC_EXP
  } scan_e;

  string       lit_word [3] = '{"null", "true", "false"};

  scan_e       phase     = SC_IDLE;
  logic [1:0]  lit_kind  = LIT_NULL;
  logic [2:0]  lit_pos   = '0;
  bit          stack_obj [MAX_DEPTH];
  int          depth     = 0;
  logic [31:0] nbytes    = '0;
  result_t     res;
  result_t     verdicts_due [$];
  int          err_cnt   = 0;

  function automatic bit is_dec(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic bit in_number(scan_e ph);
    return ph inside {SC_NUM_ZERO, SC_NUM_INT, SC_FRAC, SC_EXP};
  endfunction

  function automatic bit report(logic [1:0] st, logic [31:0] n);
    phase = SC_IDLE;
    res.status = st;
    res.span_length = n;
    return 1'b1;
  endfunction

  function automatic bit value_end();
    if (depth == 0) return report(ST_OK, nbytes);
    phase = SC_AFTER;
    return 1'b0;
  endfunction

  function automatic bit push_level(bit obj);
    if (depth >= MAX_DEPTH) return report(ST_DEEP, '0);
    stack_obj[depth] = obj;
    depth++;
    phase = obj ? SC_OBJ_FIRST : SC_ARR_FIRST;
    return 1'b0;
  endfunction

  function automatic bit pop_level();
    if (depth > 0) depth--;
    return value_end();
  endfunction

  function automatic bit value_begin(logic [7:0] b);
    case (b)
      CH_LC_N, CH_LC_T, CH_LC_F: begin
        lit_kind = (b == CH_LC_N) ? LIT_NULL : (b == CH_LC_T) ? LIT_TRUE : LIT_FALSE;
        lit_pos = 3'd1;
        phase = SC_LIT;
      end
      CH_MINUS:  phase = SC_NUM_SIGN;
      CH_ZERO:   phase = SC_NUM_ZERO;
      CH_QUOTE:  phase = SC_STR;
      CH_LBRACK: return push_level(1'b0);
      CH_LBRACE: return push_level(1'b1);
      default: begin
        if (is_dec(b)) phase = SC_NUM_INT;
        else return report(ST_BAD, '0);
      end
    endcase
    return 1'b0;
  endfunction

  // SC_IDLE here means the byte cannot extend the number
  function automatic scan_e num_next(scan_e ph, logic [7:0] b);
    bit ex;
    ex = (b == CH_LC_E) || (b == CH_UC_E);
    case (ph)
      SC_NUM_ZERO: return (b == CH_DOT) ? SC_FRAC0 : (ex ? SC_EXP0 : SC_IDLE);
      SC_NUM_INT:  return is_dec(b) ? SC_NUM_INT :
                          (b == CH_DOT) ? SC_FRAC0 : (ex ? SC_EXP0 : SC_IDLE);
      SC_FRAC:     return is_dec(b) ? SC_FRAC : (ex ? SC_EXP0 : SC_IDLE);
      default:     return is_dec(b) ? SC_EXP : SC_IDLE;
    endcase
  endfunction

  function automatic bit take(logic [7:0] b);
    scan_e ph;
    bit    top;
    ph = phase;
    // terminator of a number: not counted at top level, re-parsed as separator inside
    if (in_number(ph) && num_next(ph, b) == SC_IDLE) begin
      if (value_end()) return 1'b1;
      ph = SC_AFTER;
    end
    if (nbytes != '1) nbytes++;
    case (ph)
      SC_VALUE: return value_begin(b);
      SC_ARR_FIRST: begin
        if (b == CH_RBRACK) return pop_level();
        return value_begin(b);
      end
      SC_OBJ_FIRST: begin
        if (b == CH_RBRACE) return pop_level();
        if (b != CH_QUOTE) return report(ST_BAD, '0);
        phase = SC_KEY_STR;
      end
      SC_OBJ_KEY: begin
        if (b != CH_QUOTE) return report(ST_BAD, '0);
        phase = SC_KEY_STR;
      end
      SC_KEY_STR: begin
        if (b == CH_BSLASH) phase = SC_KEY_ESC;
        else if (b == CH_QUOTE) phase = SC_COLON;
      end
      SC_KEY_ESC: phase = SC_KEY_STR;
      SC_COLON: begin
        if (b != CH_COLON) return report(ST_BAD, '0);
        phase = SC_VALUE;
      end
      SC_AFTER: begin
        top = (depth > 0 && depth <= MAX_DEPTH) ? stack_obj[depth-1] : 1'b0;
        if (b == CH_COMMA) phase = top ? SC_OBJ_KEY : SC_VALUE;
        else if ((b == CH_RBRACK && !top) || (b == CH_RBRACE && top)) return pop_level();
        else return report(ST_BAD, '0);
      end
      SC_STR: begin
        if (b == CH_BSLASH) phase = SC_STR_ESC;
        else if (b == CH_QUOTE) return value_end();
      end
      SC_STR_ESC: phase = SC_STR;
      SC_LIT: begin
        if (lit_pos >= lit_word[lit_kind].len() || b != lit_word[lit_kind][lit_pos])
          return report(ST_BAD, '0);
        lit_pos++;
        if (lit_pos == lit_word[lit_kind].len()) return value_end();
      end
      SC_NUM_SIGN: begin
        if (b == CH_ZERO) phase = SC_NUM_ZERO;
        else if (is_dec(b)) phase = SC_NUM_INT;
        else return report(ST_BAD, '0);
      end
      SC_FRAC0: begin
        if (!is_dec(b)) return report(ST_BAD, '0);
        phase = SC_FRAC;
      end
      SC_EXP0: begin
        if (b == CH_PLUS || b == CH_MINUS) phase = SC_EXP_SIGN;
        else if (is_dec(b)) phase = SC_EXP;
        else return report(ST_BAD, '0);
      end
      SC_EXP_SIGN: begin
        if (!is_dec(b)) return report(ST_BAD, '0);
        phase = SC_EXP;
      end
      SC_NUM_ZERO, SC_NUM_INT, SC_FRAC, SC_EXP: phase = num_next(ph, b);
      default: ;
    endcase
    return 1'b0;
  endfunction

  // returns 1 when the transaction closes the value; the verdict is left in res
  function automatic bit scan_item(bit rs, bit eoi, logic [7:0] b);
    if (rs) begin
      phase = SC_VALUE;
      lit_kind = LIT_NULL;
      lit_pos = '0;
      depth = 0;
      nbytes = '0;
    end
    if (phase == SC_IDLE) return 1'b0;
    if (eoi) begin
      if (in_number(phase) && depth == 0) return report(ST_OK, nbytes);
      return report(ST_BAD, '0);
    end
    return take(b);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready && scan_item(in_tuser[0], in_tuser[1], in_tdata))
        verdicts_due.push_back(res);
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.span_length = out_tdata[33:2];
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d span %0d",
                   $time, got.status, got.span_length);
          err_cnt++;
        end else begin
          want = verdicts_due.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            err_cnt++;
          end
          if (got.span_length !== want.span_length) begin
            $display("%0t: span_length mismatch: expected %0d, actual %0d",
                     $time, want.span_length, got.span_length);
            err_cnt++;
          end
        end
      end
    end
    pending <= verdicts_due.size();
    errors <= err_cnt;
  end

endmodule

/* tb/json_value_skip_validator_tb.sv */
// Testbench top for the JSON value validator: stimulus, idle patterns and verdict.
module json_value_skip_validator_tb;
  import jvsv_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TOTAL_ITEMS = 1150;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;

  int         pending;
  int         errors;
  int         tx_idle_pct = 29;
  int         rx_idle_pct = 61;
  int         sent        = 0;
  int         share       = 0;
  int         quiet       = 0;
  logic [7:0] txt [$];

  always #4 clk = ~clk;

  json_value_skip_validator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  json_value_skip_validator_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .errors     (errors)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // every accepted transaction is counted here
  task automatic send_item(bit rs, bit eoi, logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {eoi, rs};
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic void put(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  // first byte carries restart; optional end-of-input transaction after the text
  task automatic send_txt(bit with_eoi);
    foreach (txt[i]) begin
      send_item(i == 0, 1'b0, txt[i]);
    end
    if (with_eoi) begin
      send_item(1'b0, 1'b1, 8'($urandom));
    end
    txt.delete();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void push_digits(int n);
    repeat (n) txt.push_back(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void gen_number();
    if ($urandom_range(3) == 0) txt.push_back(CH_MINUS);
    if ($urandom_range(3) == 0) begin
      txt.push_back(CH_ZERO);
    end else begin
      txt.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      push_digits($urandom_range(4));
    end
    if ($urandom_range(2) == 0) begin
      txt.push_back(CH_DOT);
      push_digits(1 + $urandom_range(3));
    end
    if ($urandom_range(2) == 0) begin
      txt.push_back($urandom_range(1) ? CH_LC_E : CH_UC_E);
      case ($urandom_range(2))
        0: txt.push_back(CH_PLUS);
        1: txt.push_back(CH_MINUS);
        default: ;
      endcase
      push_digits(1 + $urandom_range(2));
    end
  endfunction

  function automatic void gen_string();
    logic [7:0] c;
    txt.push_back(CH_QUOTE);
    repeat ($urandom_range(5)) begin
      c = 8'($urandom);
      if (c == CH_BSLASH || $urandom_range(7) == 0) begin
        txt.push_back(CH_BSLASH);
        txt.push_back(8'($urandom));
      end else if (c == CH_QUOTE) begin
        txt.push_back(CH_LC_N);
      end else begin
        txt.push_back(c);
      end
    end
    txt.push_back(CH_QUOTE);
  endfunction

  function automatic void gen_value(int lvl);
    int n;
    case ((lvl >= 3) ? $urandom_range(3) : $urandom_range(7))
      0: begin
        case ($urandom_range(2))
          0: put("null");
          1: put("true");
          default: put("false");
        endcase
      end
      1, 2: gen_number();
      3: gen_string();
      4, 5: begin
        txt.push_back(CH_LBRACK);
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) txt.push_back(CH_COMMA);
          gen_value(lvl + 1);
        end
        txt.push_back(CH_RBRACK);
      end
      default: begin
        txt.push_back(CH_LBRACE);
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) txt.push_back(CH_COMMA);
          gen_string();
          txt.push_back(CH_COLON);
          gen_value(lvl + 1);
        end
        txt.push_back(CH_RBRACE);
      end
    endcase
  endfunction

  // nesting around the stack limit, arrays and objects mixed
  function automatic void gen_deep();
    logic [7:0] closers [$];
    repeat ($urandom_range(MAX_DEPTH_DEF - 3, MAX_DEPTH_DEF + 2)) begin
      if ($urandom_range(1)) begin
        txt.push_back(CH_LBRACK);
        closers.push_front(CH_RBRACK);
      end else begin
        put("{\"k\":");
        closers.push_front(CH_RBRACE);
      end
    end
    gen_value(3);
    foreach (closers[i]) txt.push_back(closers[i]);
  endfunction

  task automatic random_run(int items);
    int stop;
    int pick;
    int cut;
    stop = sent + items;
    while (sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 4) gen_deep();
      else gen_value(0);
      if (pick < 70) begin
        send_txt(1'b0);
        // trailers: end a top-level number, or get ignored once idle
        case ($urandom_range(3))
          0, 1: send_item(1'b0, 1'b1, 8'($urandom));
          2: send_item(1'b0, 1'b0, 8'($urandom));
          default: ;
        endcase
      end else if (pick < 85) begin
        cut = $urandom_range(txt.size() - 1);
        if ($urandom_range(1)) begin
          txt[cut] = 8'($urandom);
        end else begin
          case ($urandom_range(5))
            0: txt[cut] = CH_COMMA;
            1: txt[cut] = CH_RBRACK;
            2: txt[cut] = CH_RBRACE;
            3: txt[cut] = CH_COLON;
            4: txt[cut] = CH_QUOTE;
            default: txt[cut] = CH_BSLASH;
          endcase
        end
        send_txt(1'b1);
      end else if (pick < 97) begin
        // truncated text; with no end of input the next restart drops the scan
        cut = $urandom_range(txt.size() - 1);
        while (txt.size() > cut + 1) void'(txt.pop_back());
        send_txt(pick < 93);
      end else begin
        txt.delete();
        repeat ($urandom_range(1, 6)) begin
          send_item($urandom_range(3) == 0, $urandom_range(3) == 0, 8'($urandom));
        end
      end
    end
  endtask

  task automatic directed();
    put("null");      send_txt(1'b0);
    put("true");      send_txt(1'b0);
    put("false");     send_txt(1'b0);
    put("nul");       send_txt(1'b1);
    put("trUe");      send_txt(1'b0);
    put("-0");        send_txt(1'b1);
    put("12.5e+3");   send_txt(1'b1);
    put("0E-7");      send_txt(1'b1);
    put("7x");        send_txt(1'b0);  // terminator not counted
    put("01");        send_txt(1'b0);
    put("-a");        send_txt(1'b0);
    put("1.e");       send_txt(1'b0);
    put("2e+");       send_txt(1'b1);
    put("\"a\\\"b\"");  send_txt(1'b0);
    txt.push_back(CH_QUOTE); txt.push_back(8'h00); txt.push_back(8'hFF);
    txt.push_back(CH_BSLASH); txt.push_back(CH_BSLASH); txt.push_back(CH_QUOTE);
    send_txt(1'b0);
    put("\"abc");     send_txt(1'b1);
    put("[]");        send_txt(1'b0);
    put("{}");        send_txt(1'b0);
    put("{\"k\":[true,{},-1.5E9],\"\\\"\":\"v\"}"); send_txt(1'b0);
    put("[1,]");      send_txt(1'b0);
    put("[1 2]");     send_txt(1'b0);
    put("{\"a\"1}");  send_txt(1'b0);
    put("[1}");       send_txt(1'b0);
    put("{\"a\":0]"); send_txt(1'b0);
    // deepest legal nesting, then one level past the stack
    repeat (MAX_DEPTH_DEF) txt.push_back(CH_LBRACK);
    repeat (MAX_DEPTH_DEF) txt.push_back(CH_RBRACK);
    send_txt(1'b0);
    repeat (MAX_DEPTH_DEF + 1) txt.push_back(CH_LBRACK);
    send_txt(1'b0);
    // restart while a scan is open drops it silently
    put("[1,");       send_txt(1'b0);
    put("true");      send_txt(1'b0);
    send_item(1'b1, 1'b1, 8'hFF);
    // no scan active: ignored
    send_item(1'b0, 1'b0, CH_LBRACK);
    send_item(1'b0, 1'b1, 8'h00);
    put("x");         send_txt(1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    directed();
    share = (TOTAL_ITEMS - sent) / 3;
    random_run(share);
    drain();
    tx_idle_pct = 61;
    rx_idle_pct = 29;
    random_run(share);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_run(TOTAL_ITEMS - sent);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/jvsv_pkg.sv
design/jvsv_in_stage.sv
design/jvsv_scan.sv
design/json_value_skip_validator.sv
tb/json_value_skip_validator_chk.sv
tb/json_value_skip_validator_tb.sv
